// ===== design/ifsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifsp_pkg
// Shared types, constants and the byte-wide crc update for the frame parser.
// ----------------------------------------------------------------------------
package ifsp_pkg;

    localparam int BQ_DEPTH  = 2;
    localparam int RES_DEPTH = 4;

    localparam logic [7:0] FUNC_READ_HOLD  = 8'h03;
    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0] FUNC_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FUNC_WRITE_MULT = 8'h10;
    localparam logic [7:0] EXC_BIT         = 8'h80;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CRC_ERR   = 3'd1;
    localparam logic [2:0] ST_EXCEPTION = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    // byte queue entry, with the classification done on entry
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
        logic       is_start;
        logic       func_ok;
    } bq_entry_t;

    typedef struct packed {
        logic        kind;
        logic        req_flag;
        logic [6:0]  func_code;
        logic [15:0] start_addr;
        logic [15:0] reg_value;
        logic [15:0] reg_count;
        logic [2:0]  status;
        logic [7:0]  exc_code;
        logic [15:0] serial_high;
        logic [63:0] serial_low;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] bq_count;
    } front_stat_t;

    function automatic logic [15:0] crc_add(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ 16'hA001;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/ifsp_byte_if.sv =====
// ----------------------------------------------------------------------------
// ifsp_byte_if
// Byte channel: one bus byte and its end-of-buffer flag per transfer.
// ----------------------------------------------------------------------------
interface ifsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

// ===== design/ifsp_result_if.sv =====
// ----------------------------------------------------------------------------
// ifsp_result_if
// Result channel: register value items and frame summaries.
// ----------------------------------------------------------------------------
interface ifsp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        req_flag;
    logic [6:0]  func_code;
    logic [15:0] start_addr;
    logic [15:0] reg_value;
    logic [15:0] reg_count;
    logic [2:0]  status;
    logic [7:0]  exc_code;
    logic [15:0] serial_high;
    logic [63:0] serial_low;
    logic        last;

    modport source (output valid, output kind, output req_flag, output func_code,
                    output start_addr, output reg_value, output reg_count, output status,
                    output exc_code, output serial_high, output serial_low,
                    output last, input ready);
    modport sink   (input valid, input kind, input req_flag, input func_code,
                    input start_addr, input reg_value, input reg_count, input status,
                    input exc_code, input serial_high, input serial_low,
                    input last, output ready);
endinterface

// ===== design/inverter_frame_stream_parser.sv =====
// ----------------------------------------------------------------------------
// inverter_frame_stream_parser
// Finds request and response frames in a bus byte stream and reports them.
// ----------------------------------------------------------------------------
// bytes: one bus byte per transfer, end_of_buffer on the last byte of a buffer.
// results: register value items as their two bytes arrive, then one frame
// summary (kind 1, last 1) per frame with crc, exception or invalid status; truncated frames get a
// summary with status 4.
// the front takes one byte per cycle into a two-entry queue; the parser takes
// one byte per cycle from it and writes up to two items into the result queue
// (RES_DEPTH entries), where result items are registered before they are offered.
// throughput is one byte per cycle while the receiver takes one item per
// cycle; a byte giving two items needs one extra output transfer.
// the parser stalls when fewer than two result slots are free, and the byte
// queue then fills and drops ready.
// reset clears frame state except the serial bytes; the parser hunts for a frame start.
// ----------------------------------------------------------------------------
module inverter_frame_stream_parser #(
    parameter int RES_DEPTH = ifsp_pkg::RES_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    ifsp_byte_if.sink     bytes,
    ifsp_result_if.source results
);
    import ifsp_pkg::*;

    bq_entry_t   head;
    logic        head_valid;
    logic        pop;
    front_stat_t stat;

    ifsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .stat       (stat)
    );

    ifsp_back #(.RES_DEPTH(RES_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .results    (results)
    );

    a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.last == results.kind))
        else $error("last and kind differ");

    a_req_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.req_flag) |-> results.kind)
        else $error("request flag on value item");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> (stat.bq_count == 2'(BQ_DEPTH)))
        else $error("byte queue stalled while not full");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty byte queue");

endmodule

// ===== design/ifsp_front.sv =====
// ----------------------------------------------------------------------------
// ifsp_front
// Accepts bus bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ifsp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    ifsp_byte_if.sink              bytes,
    output ifsp_pkg::bq_entry_t    head,
    output logic                   head_valid,
    input  logic                   pop,
    output ifsp_pkg::front_stat_t  stat
);
    import ifsp_pkg::*;

    bq_entry_t  ent_reg [BQ_DEPTH];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic [7:0] base;
    bq_entry_t  new_ent;

    assign bytes.ready = (count_reg != 2'(BQ_DEPTH));
    assign push        = bytes.valid && bytes.ready;
    assign head_valid  = (count_reg != 2'd0);
    assign head        = ent_reg[rd_reg];
    assign stat.bq_count = count_reg;

    always_comb
    begin
        base = {1'b0, bytes.rx_byte[6:0]};
        new_ent.rx_byte       = bytes.rx_byte;
        new_ent.end_of_buffer = bytes.end_of_buffer;
        new_ent.is_start      = (bytes.rx_byte[7:1] == 7'd0);
        new_ent.func_ok       = (base == FUNC_READ_HOLD) || (base == FUNC_READ_INPUT)
                             || (base == FUNC_WRITE_ONE) || (base == FUNC_WRITE_MULT);
        rd_next    = pop ? ~rd_reg : rd_reg;
        wr_next    = push ? ~wr_reg : wr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= new_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/ifsp_back.sv =====
// ----------------------------------------------------------------------------
// ifsp_back
// Frame parser: walks frames one byte per cycle while two result slots are free, and queues result items.
// ----------------------------------------------------------------------------
module ifsp_back #(
    parameter int RES_DEPTH = ifsp_pkg::RES_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ifsp_pkg::bq_entry_t head,
    input  logic                head_valid,
    output logic                pop,
    ifsp_result_if.source       results
);
    import ifsp_pkg::*;

    localparam int PW = $clog2(RES_DEPTH);
    localparam int CW = $clog2(RES_DEPTH + 1);

    typedef enum logic [7:0] {
        FT_NONE   = 8'b0000_0001,
        FT_REQ    = 8'b0000_0010,
        FT_PEND   = 8'b0000_0100,
        FT_EXC    = 8'b0000_1000,
        FT_READ   = 8'b0001_0000,
        FT_WS     = 8'b0010_0000,
        FT_WM     = 8'b0100_0000,
        FT_BADEXC = 8'b1000_0000
    } ft_t;

    logic [8:0]  pos_reg, pos_next;
    ft_t         ft_reg, ft_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  dcnt_reg, dcnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  serial_reg [10];
    logic [7:0]  low_reg, low_next;
    logic [15:0] vf_reg, vf_next;
    logic [7:0]  crcl_reg, crcl_next;
    logic [7:0]  exc_reg, exc_next;

    res_t        q_reg [RES_DEPTH];
    logic [PW-1:0] rp_reg, wp_reg, wp1;
    logic [CW-1:0] cnt_reg;

    res_t        r0, r1, ser_item;
    logic [1:0]  n;
    logic        go, out_pop;
    logic [7:0]  b;
    logic [8:0]  len1, len2;
    logic [15:0] rx_crc;
    logic [2:0]  st;
    logic [63:0] ser_lo;

    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p);
        return (p == PW'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [8:0] flen(input ft_t f, input logic [7:0] d);
        case (f)
            FT_EXC, FT_BADEXC: flen = 9'd17;
            FT_READ:           flen = 9'd17 + {1'b0, d};
            default:           flen = 9'd18;
        endcase
    endfunction

    assign go      = head_valid && (cnt_reg <= CW'(RES_DEPTH - 2));
    assign pop     = go;
    assign b       = head.rx_byte;
    assign out_pop = results.valid && results.ready;
    assign wp1     = wrap(wp_reg);

    always_comb
    begin
        ser_lo = '0;
        for (int i = 2; i < 10; i++) begin
            ser_lo = {ser_lo[55:0], serial_reg[i]};
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        ft_next   = ft_reg;
        func_next = func_reg;
        addr_next = addr_reg;
        dcnt_next = dcnt_reg;
        crc_next  = crc_reg;
        low_next  = low_reg;
        vf_next   = vf_reg;
        crcl_next = crcl_reg;
        exc_next  = exc_reg;
        n         = 2'd0;
        r0        = '0;
        r1        = '0;
        len1      = flen(ft_reg, dcnt_reg);
        len2      = len1;
        rx_crc    = {b, crcl_reg};
        st        = ST_OK;
        ser_item  = '0;
        ser_item.func_code   = func_reg[6:0];
        ser_item.start_addr  = addr_reg;
        ser_item.serial_high = {serial_reg[0], serial_reg[1]};
        ser_item.serial_low  = ser_lo;

        if (pos_reg == 9'd0)
        begin
            if (head.is_start)
            begin
                ft_next   = b[0] ? FT_PEND : FT_REQ;
                pos_next  = 9'd1;
                func_next = 8'd0;
                crc_next  = crc_add(16'hFFFF, b);
            end
        end
        else if (ft_reg == FT_PEND)
        begin
            if (b[7] || head.func_ok)
            begin
                if (b[7])
                    ft_next = head.func_ok ? FT_EXC : FT_BADEXC;
                else if (b[6:0] == FUNC_WRITE_ONE[6:0])
                    ft_next = FT_WS;
                else if (b[6:0] == FUNC_WRITE_MULT[6:0])
                    ft_next = FT_WM;
                else
                    ft_next = FT_READ;
                func_next = b;
                dcnt_next = 8'd0;
                crc_next  = crc_add(crc_reg, b);
                pos_next  = 9'd2;
            end
            else
            begin
                // re-examine the bad function byte as a frame start
                pos_next  = 9'd0;
                ft_next   = FT_NONE;
                func_next = 8'd0;
                if (head.is_start)
                begin
                    ft_next  = b[0] ? FT_PEND : FT_REQ;
                    pos_next = 9'd1;
                    crc_next = crc_add(16'hFFFF, b);
                end
            end
        end
        else
        begin
            if (pos_reg < len1 - 9'd2)
                crc_next = crc_add(crc_reg, b);
            if (pos_reg == 9'd12)
                addr_next = {addr_reg[15:8], b};
            if (pos_reg == 9'd13)
                addr_next = {b, addr_reg[7:0]};
            if (ft_reg == FT_READ)
            begin
                if (pos_reg == 9'd14)
                    dcnt_next = b;
                else if (pos_reg >= 9'd15 && pos_reg < 9'd15 + {1'b0, dcnt_reg})
                begin
                    if (!pos_reg[0])
                    begin
                        // data byte at odd offset closes a value
                        r0 = ser_item;
                        r0.reg_value = {b, low_reg};
                        r0.reg_count = {9'd0, dcnt_reg[7:1]};
                        n = 2'd1;
                    end
                    else
                        low_next = b;
                end
            end
            else if (ft_reg == FT_WS || ft_reg == FT_WM)
            begin
                if (pos_reg == 9'd14)
                    vf_next = {8'd0, b};
                if (pos_reg == 9'd15)
                begin
                    vf_next = {b, vf_reg[7:0]};
                    if (ft_reg == FT_WS)
                    begin
                        r0 = ser_item;
                        r0.reg_value = {b, vf_reg[7:0]};
                        r0.reg_count = 16'd1;
                        n = 2'd1;
                    end
                end
            end
            else if (ft_reg == FT_EXC)
            begin
                if (pos_reg == 9'd14)
                    exc_next = b;
            end
            len2 = flen(ft_reg, dcnt_next);
            if (pos_reg == len2 - 9'd2)
                crcl_next = b;
            if (pos_reg == len2 - 9'd1)
            begin
                st = (rx_crc != crc_next) ? ST_CRC_ERR : ST_OK;
                r1 = ser_item;
                r1.kind = 1'b1;
                r1.last = 1'b1;
                r1.status = st;
                case (ft_reg)
                    FT_REQ:
                    begin
                        r1 = '0;
                        r1.kind = 1'b1;
                        r1.last = 1'b1;
                        r1.req_flag = 1'b1;
                    end
                    FT_EXC:
                    begin
                        r1.status = ST_EXCEPTION;
                        r1.exc_code = exc_reg;
                    end
                    FT_BADEXC:
                    begin
                        r1 = '0;
                        r1.kind = 1'b1;
                        r1.last = 1'b1;
                        r1.func_code = func_reg[6:0];
                        r1.status = ST_INVALID;
                    end
                    FT_READ: r1.reg_count = {9'd0, dcnt_next[7:1]};
                    FT_WS:   r1.reg_count = 16'd1;
                    default: r1.reg_count = vf_next;
                endcase
                if (n == 2'd0)
                    r0 = r1;
                n = n + 2'd1;
                pos_next = 9'd0;
                ft_next  = FT_NONE;
            end
            else
                pos_next = pos_reg + 9'd1;
        end

        if (head.end_of_buffer && pos_next != 9'd0)
        begin
            r1 = '0;
            r1.kind = 1'b1;
            r1.last = 1'b1;
            r1.req_flag = (ft_next == FT_REQ);
            r1.func_code = func_next[6:0];
            r1.status = ST_TRUNC;
            if (n == 2'd0)
                r0 = r1;
            n = n + 2'd1;
            pos_next = 9'd0;
            ft_next  = FT_NONE;
        end
    end

    assign results.valid          = (cnt_reg != '0);
    assign results.kind           = q_reg[rp_reg].kind;
    assign results.req_flag       = q_reg[rp_reg].req_flag;
    assign results.func_code      = q_reg[rp_reg].func_code;
    assign results.start_addr     = q_reg[rp_reg].start_addr;
    assign results.reg_value      = q_reg[rp_reg].reg_value;
    assign results.reg_count      = q_reg[rp_reg].reg_count;
    assign results.status         = q_reg[rp_reg].status;
    assign results.exc_code       = q_reg[rp_reg].exc_code;
    assign results.serial_high    = q_reg[rp_reg].serial_high;
    assign results.serial_low     = q_reg[rp_reg].serial_low;
    assign results.last           = q_reg[rp_reg].last;

    // payload: result queue and serial bytes
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (n != 2'd0)
                q_reg[wp_reg] <= r0;
            if (n == 2'd2)
                q_reg[wp1] <= r1;
            if (pos_reg >= 9'd2 && pos_reg <= 9'd11 && ft_reg != FT_PEND)
                serial_reg[4'(pos_reg - 9'd2)] <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 9'd0;
            ft_reg    <= FT_NONE;
            func_reg  <= 8'd0;
            addr_reg  <= 16'd0;
            dcnt_reg  <= 8'd0;
            crc_reg   <= 16'hFFFF;
            low_reg   <= 8'd0;
            vf_reg    <= 16'd0;
            crcl_reg  <= 8'd0;
            exc_reg   <= 8'd0;
            rp_reg    <= '0;
            wp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (go)
            begin
                pos_reg   <= pos_next;
                ft_reg    <= ft_next;
                func_reg  <= func_next;
                addr_reg  <= addr_next;
                dcnt_reg  <= dcnt_next;
                crc_reg   <= crc_next;
                low_reg   <= low_next;
                vf_reg    <= vf_next;
                crcl_reg  <= crcl_next;
                exc_reg   <= exc_next;
                if (n == 2'd1)
                    wp_reg <= wp1;
                else if (n == 2'd2)
                    wp_reg <= wrap(wp1);
            end
            if (out_pop)
                rp_reg <= wrap(rp_reg);
            cnt_reg <= cnt_reg + (go ? CW'(n) : CW'(0)) - CW'(out_pop);
        end
    end

endmodule
